@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/gpt_pkg.sv @@
// Package for the G-code position tracker: widths, codes, command word type.
// Depends on nothing.
`default_nettype none
package gpt_pkg;
    localparam int MaxNumChars = 8;
    localparam int FracBits    = 16;
    localparam int CoordW      = 48;
    localparam int MantW       = 27;
    localparam int CntW        = 4;
    localparam int FracW       = 3;
    localparam int DenW        = 25;
    localparam int RemW        = DenW + 1;
    localparam int DivNW       = MantW + FracBits + 2;
    localparam int DivCntW     = 6;
    localparam int QDepth      = 4;
    localparam int QPtrW       = 2;

    localparam logic [1:0] FUNC_CHAR  = 2'd0;
    localparam logic [1:0] FUNC_EOL   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_G   = 8'h47;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Y   = 8'h59;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [MantW-1:0] G_RAPID  = MantW'(0);
    localparam logic [MantW-1:0] G_LINEAR = MantW'(1);
    localparam logic [MantW-1:0] G_ABS    = MantW'(90);
    localparam logic [MantW-1:0] G_INC    = MantW'(91);

    typedef logic signed [CoordW-1:0] t_coord;

    typedef enum logic [1:0] {
        CMD_WORD,
        CMD_EOL,
        CMD_CLEAR
    } t_cmd_kind;

    typedef enum logic [2:0] {
        LT_NONE,
        LT_G,
        LT_X,
        LT_Y,
        LT_Z,
        LT_OTHER
    } t_letter;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

    typedef struct packed {
        t_cmd_kind        kind;
        logic             has_word;
        t_letter          letter;
        logic [MantW-1:0] mant;
        logic [FracW-1:0] frac;
        logic             neg;
        logic             dot;
        logic             num_ok;
    } t_cmd;

    function automatic logic [DenW-1:0] pow10(input logic [FracW-1:0] f);
        logic [DenW-1:0] p;
        case (f)
            3'd0:    p = DenW'(1);
            3'd1:    p = DenW'(10);
            3'd2:    p = DenW'(100);
            3'd3:    p = DenW'(1000);
            3'd4:    p = DenW'(10000);
            3'd5:    p = DenW'(100000);
            3'd6:    p = DenW'(1000000);
            3'd7:    p = DenW'(10000000);
            default: p = DenW'(1);
        endcase
        return p;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/gpt_front.sv @@
// Front end: lexes characters, collects words, pushes command words.
// Depends on gpt_pkg.
`default_nettype none
module gpt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [1:0]    i_func,
    input  wire logic [7:0]    i_char_code,
    output gpt_pkg::t_cmd      o_cmd,
    output logic               o_cmd_vld
);
    logic                          r_skip, n_skip;
    logic                          r_comment, n_comment;
    gpt_pkg::t_letter              r_letter, n_letter;
    logic [gpt_pkg::MantW-1:0]     r_mant, n_mant;
    logic [gpt_pkg::CntW-1:0]      r_cnt, n_cnt;
    logic [gpt_pkg::FracW-1:0]     r_frac, n_frac;
    logic                          r_neg, n_neg, r_dot, n_dot, r_bad, n_bad, r_dig, n_dig;

    logic [7:0]                    upper;
    logic                          is_dig, is_alpha, is_num, take_new;
    logic [gpt_pkg::MantW-1:0]     w_mant;
    logic [gpt_pkg::CntW-1:0]      w_cnt;
    logic [gpt_pkg::FracW-1:0]     w_frac;
    logic                          w_neg, w_dot, w_bad, w_dig;
    gpt_pkg::t_letter              new_letter;
    logic [7:0]                    digit;

    always_comb begin
        upper = (i_char_code >= gpt_pkg::CH_LO_A && i_char_code <= gpt_pkg::CH_LO_Z)
              ? i_char_code - gpt_pkg::CASE_GAP : i_char_code;
        is_dig = i_char_code >= gpt_pkg::CH_ZERO && i_char_code <= gpt_pkg::CH_NINE;
        is_alpha = upper >= gpt_pkg::CH_UP_A && upper <= gpt_pkg::CH_UP_Z;
        is_num = is_dig || i_char_code == gpt_pkg::CH_MINUS || i_char_code == gpt_pkg::CH_DOT;
        digit = i_char_code - gpt_pkg::CH_ZERO;
        if (upper == gpt_pkg::CH_UP_G) begin
            new_letter = gpt_pkg::LT_G;
        end else if (upper == gpt_pkg::CH_UP_X) begin
            new_letter = gpt_pkg::LT_X;
        end else if (upper == gpt_pkg::CH_UP_Y) begin
            new_letter = gpt_pkg::LT_Y;
        end else if (upper == gpt_pkg::CH_UP_Z) begin
            new_letter = gpt_pkg::LT_Z;
        end else begin
            new_letter = gpt_pkg::LT_OTHER;
        end

        n_skip = r_skip;   n_comment = r_comment; n_letter = r_letter;
        n_mant = r_mant;   n_cnt = r_cnt;         n_frac = r_frac;
        n_neg = r_neg;     n_dot = r_dot;         n_bad = r_bad;   n_dig = r_dig;
        w_mant = r_mant;   w_cnt = r_cnt;         w_frac = r_frac;
        w_neg = r_neg;     w_dot = r_dot;         w_bad = r_bad;   w_dig = r_dig;
        take_new = 1'b0;
        o_cmd_vld = 1'b0;
        o_cmd.kind = gpt_pkg::CMD_WORD;
        o_cmd.has_word = r_letter != gpt_pkg::LT_NONE;

        if (i_take) begin
            case (i_func)
                gpt_pkg::FUNC_CHAR: begin
                    if (!r_skip) begin
                        if (r_comment) begin
                            if (i_char_code == gpt_pkg::CH_RPAREN) begin
                                n_comment = 1'b0;
                            end
                        end else begin
                            take_new = 1'b1;
                            if (r_letter != gpt_pkg::LT_NONE) begin
                                if (is_num) begin
                                    take_new = 1'b0;
                                    if (is_dig) begin
                                        w_mant = gpt_pkg::MantW'(r_mant * gpt_pkg::MantW'(10)
                                               + gpt_pkg::MantW'(digit[3:0]));
                                        w_dig = 1'b1;
                                        if (r_dot) begin
                                            w_frac = r_frac + 1'b1;
                                        end
                                    end else if (i_char_code == gpt_pkg::CH_MINUS) begin
                                        if (r_cnt != '0) begin
                                            w_bad = 1'b1;
                                        end else begin
                                            w_neg = 1'b1;
                                        end
                                    end else begin
                                        if (r_dot) begin
                                            w_bad = 1'b1;
                                        end
                                        w_dot = 1'b1;
                                    end
                                    w_cnt = r_cnt + 1'b1;
                                    n_mant = w_mant; n_cnt = w_cnt; n_frac = w_frac;
                                    n_neg = w_neg;   n_dot = w_dot; n_bad = w_bad; n_dig = w_dig;
                                    if (w_cnt >= gpt_pkg::CntW'(gpt_pkg::MaxNumChars)) begin
                                        o_cmd_vld = 1'b1;
                                        n_letter = gpt_pkg::LT_NONE;
                                    end
                                end else begin
                                    o_cmd_vld = 1'b1;
                                    n_letter = gpt_pkg::LT_NONE;
                                end
                            end
                            if (take_new) begin
                                if (i_char_code == gpt_pkg::CH_LPAREN) begin
                                    n_comment = 1'b1;
                                end else if (i_char_code == gpt_pkg::CH_SEMI) begin
                                    n_skip = 1'b1;
                                end else if (is_alpha) begin
                                    n_letter = new_letter;
                                end
                            end
                            if (n_letter != r_letter || take_new) begin
                                n_mant = '0; n_cnt = '0; n_frac = '0;
                                n_neg = 1'b0; n_dot = 1'b0; n_bad = 1'b0; n_dig = 1'b0;
                            end
                        end
                    end
                end
                gpt_pkg::FUNC_EOL, gpt_pkg::FUNC_CLEAR: begin
                    o_cmd_vld = 1'b1;
                    o_cmd.kind = (i_func == gpt_pkg::FUNC_EOL) ? gpt_pkg::CMD_EOL
                                                               : gpt_pkg::CMD_CLEAR;
                    n_skip = 1'b0; n_comment = 1'b0; n_letter = gpt_pkg::LT_NONE;
                    n_mant = '0; n_cnt = '0; n_frac = '0;
                    n_neg = 1'b0; n_dot = 1'b0; n_bad = 1'b0; n_dig = 1'b0;
                end
                default: begin
                end
            endcase
        end

        o_cmd.letter = r_letter;
        o_cmd.mant   = w_mant;
        o_cmd.frac   = w_frac;
        o_cmd.neg    = w_neg;
        o_cmd.dot    = w_dot;
        o_cmd.num_ok = !w_bad && w_dig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0; r_comment <= 1'b0; r_letter <= gpt_pkg::LT_NONE;
            r_mant <= '0;   r_cnt <= '0;       r_frac <= '0;
            r_neg <= 1'b0;  r_dot <= 1'b0;     r_bad <= 1'b0;  r_dig <= 1'b0;
        end else begin
            r_skip <= n_skip; r_comment <= n_comment; r_letter <= n_letter;
            r_mant <= n_mant; r_cnt <= n_cnt;         r_frac <= n_frac;
            r_neg <= n_neg;   r_dot <= n_dot;         r_bad <= n_bad;  r_dig <= n_dig;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/gpt_queue.sv @@
// Short command queue between front and back end.
// Depends on gpt_pkg.
`default_nettype none
module gpt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  gpt_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output gpt_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    gpt_pkg::t_cmd                 r_mem [gpt_pkg::QDepth];
    logic [gpt_pkg::QPtrW-1:0]     r_wr, r_rd;
    logic [gpt_pkg::QPtrW:0]       r_cnt;

    assign o_full  = r_cnt == (gpt_pkg::QPtrW+1)'(gpt_pkg::QDepth);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (gpt_pkg::QPtrW+1)'(i_push) - (gpt_pkg::QPtrW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/gpt_back.sv @@
// Back end: runs G words, converts and applies moves, keeps bounds, emits results.
// Depends on gpt_pkg.
`default_nettype none
module gpt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_vld,
    input  gpt_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output gpt_pkg::t_coord    o_pos [3],
    output gpt_pkg::t_coord    o_bnd [6],
    output logic [5:0]         o_flags
);
    gpt_pkg::t_back_state          r_state, n_state;
    gpt_pkg::t_cmd                 r_cmd;
    gpt_pkg::t_coord               r_pos [3];
    gpt_pkg::t_coord               n_pos [3];
    gpt_pkg::t_coord               r_bnd [6];
    gpt_pkg::t_coord               n_bnd [6];
    logic [5:0]                    r_flags, n_flags;
    logic                          r_inc, n_inc, r_move, n_move, r_oval;
    logic [gpt_pkg::RemW-1:0]      r_rem, rs;
    logic [gpt_pkg::DivNW-1:0]     r_num;
    logic [gpt_pkg::DenW-1:0]      r_den, p;
    logic [gpt_pkg::DivCntW-1:0]   r_dcnt;
    logic                          ge;

    gpt_pkg::t_cmd                 cur;
    logic                          head_xyz, need_div, cur_ready, out_free, exec, start;
    logic [gpt_pkg::CoordW-1:0]    mag;
    gpt_pkg::t_coord               val, moved;
    logic signed [gpt_pkg::CoordW:0] sum;
    logic [1:0]                    ax;
    logic [2:0]                    lo, hi;
    logic [gpt_pkg::MantW-1:0]     g;

    always_comb begin
        head_xyz = i_q_cmd.letter == gpt_pkg::LT_X || i_q_cmd.letter == gpt_pkg::LT_Y
                || i_q_cmd.letter == gpt_pkg::LT_Z;
        need_div = i_q_cmd.has_word && head_xyz && i_q_cmd.num_ok && i_q_cmd.frac != '0
                && r_move;
        cur = (r_state == gpt_pkg::BK_DIV) ? r_cmd : i_q_cmd;
        cur_ready = (r_state == gpt_pkg::BK_DIV) ? (r_dcnt == '0) : (i_q_vld && !need_div);
        out_free = !r_oval || i_ready;
        exec = cur_ready && (cur.kind != gpt_pkg::CMD_EOL || out_free);
        start = r_state == gpt_pkg::BK_IDLE && i_q_vld && need_div;
        o_pop = start || (r_state == gpt_pkg::BK_IDLE && exec);
        p = gpt_pkg::pow10(i_q_cmd.frac);

        rs = {r_rem[gpt_pkg::RemW-2:0], r_num[gpt_pkg::DivNW-1]};
        ge = rs >= {1'b0, r_den};

        if (r_state == gpt_pkg::BK_DIV) begin
            mag = gpt_pkg::CoordW'(r_num);
        end else begin
            mag = gpt_pkg::CoordW'({cur.mant, {gpt_pkg::FracBits{1'b0}}});
        end
        if (!cur.num_ok) begin
            mag = '0;
        end
        val = cur.neg ? -$signed(mag) : $signed(mag);

        ax = 2'(cur.letter - gpt_pkg::LT_X);
        lo = {ax, 1'b0};
        hi = {ax, 1'b1};
        sum = {r_pos[ax][gpt_pkg::CoordW-1], r_pos[ax]} + {val[gpt_pkg::CoordW-1], val};
        if (sum[gpt_pkg::CoordW] != sum[gpt_pkg::CoordW-1]) begin
            moved = sum[gpt_pkg::CoordW] ? {1'b1, {(gpt_pkg::CoordW-1){1'b0}}}
                                         : {1'b0, {(gpt_pkg::CoordW-1){1'b1}}};
        end else begin
            moved = sum[gpt_pkg::CoordW-1:0];
        end
        if (!r_inc) begin
            moved = val;
        end
        g = (cur.num_ok && !cur.dot) ? cur.mant : '0;

        n_state = r_state;
        n_pos = r_pos; n_bnd = r_bnd; n_flags = r_flags;
        n_inc = r_inc; n_move = r_move;
        if (start) begin
            n_state = gpt_pkg::BK_DIV;
        end
        if (exec) begin
            n_state = gpt_pkg::BK_IDLE;
            case (cur.kind)
                gpt_pkg::CMD_CLEAR: begin
                    for (int i = 0; i < 3; i++) begin
                        n_pos[i] = '0;
                    end
                    for (int i = 0; i < 6; i++) begin
                        n_bnd[i] = '0;
                    end
                    n_flags = '0; n_inc = 1'b0; n_move = 1'b0;
                end
                gpt_pkg::CMD_WORD, gpt_pkg::CMD_EOL: begin
                    if (cur.has_word) begin
                        if (cur.letter == gpt_pkg::LT_G) begin
                            if (g == gpt_pkg::G_RAPID || (g == gpt_pkg::G_LINEAR && !cur.neg)) begin
                                n_move = 1'b1;
                            end else if (!cur.neg && g == gpt_pkg::G_ABS) begin
                                n_inc = 1'b0;
                            end else if (!cur.neg && g == gpt_pkg::G_INC) begin
                                n_inc = 1'b1;
                            end
                        end else if ((cur.letter == gpt_pkg::LT_X || cur.letter == gpt_pkg::LT_Y
                                   || cur.letter == gpt_pkg::LT_Z) && r_move) begin
                            n_pos[ax] = moved;
                            if (!r_flags[lo] || r_bnd[lo] > moved) begin
                                n_bnd[lo] = moved;
                                n_flags[lo] = 1'b1;
                            end
                            if (!r_flags[hi] || r_bnd[hi] < moved) begin
                                n_bnd[hi] = moved;
                                n_flags[hi] = 1'b1;
                            end
                        end
                    end
                    if (cur.kind == gpt_pkg::CMD_EOL) begin
                        n_move = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd  <= i_q_cmd;
            r_num  <= gpt_pkg::DivNW'({i_q_cmd.mant, {(gpt_pkg::FracBits+1){1'b0}}})
                    + gpt_pkg::DivNW'(p);
            r_den  <= {p[gpt_pkg::DenW-2:0], 1'b0};
            r_rem  <= '0;
        end else if (r_state == gpt_pkg::BK_DIV && r_dcnt != '0) begin
            r_rem  <= ge ? rs - {1'b0, r_den} : rs;
            r_num  <= {r_num[gpt_pkg::DivNW-2:0], ge};
        end
        if (exec && cur.kind == gpt_pkg::CMD_EOL) begin
            o_pos   <= n_pos;
            o_bnd   <= n_bnd;
            o_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpt_pkg::BK_IDLE;
            r_dcnt  <= '0;
            r_oval  <= 1'b0;
            r_flags <= '0;
            r_inc   <= 1'b0;
            r_move  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
            end
            for (int i = 0; i < 6; i++) begin
                r_bnd[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (start) begin
                r_dcnt <= gpt_pkg::DivCntW'(gpt_pkg::DivNW);
            end else if (r_state == gpt_pkg::BK_DIV && r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
            if (exec && cur.kind == gpt_pkg::CMD_EOL) begin
                r_oval <= 1'b1;
            end else if (i_ready) begin
                r_oval <= 1'b0;
            end
            r_pos <= n_pos; r_bnd <= n_bnd; r_flags <= n_flags;
            r_inc <= n_inc; r_move <= n_move;
        end
    end

    assign o_valid = r_oval;
endmodule
`default_nettype wire

@@ hw/rtl/gcode_position_and_bounds_tracker.sv @@
// G-code position and bounding-box tracker, top level.
// Input channel: i_valid/o_ready with i_func (0 character, 1 end of line,
// 2 clear program) and i_char_code. Output channel: o_valid/i_ready with
// the position, six bounds and o_bounds_valid, one word per end of line.
// The front end takes one character per cycle and pushes command words into
// a four-entry queue; o_ready drops only while that queue is full.
// The back end runs one command per cycle, except while dividing or while a
// line end waits for i_ready. An X, Y or Z move whose number has a fractional
// part goes through a 1-bit-per-cycle divider in the back end, hidden by the
// queue when the following text is long enough.
// When i_ready is low the result holds; the back end stops at the next line
// end while the front keeps filling the queue.
// Reset (i_rst_n low, synchronous) and the clear function both zero the
// position, bounds and modes; reset also empties the queue.
// Depends on gpt_pkg, gpt_front, gpt_queue, gpt_back.
`default_nettype none
module gcode_position_and_bounds_tracker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [7:0]                    i_char_code,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [gpt_pkg::CoordW-1:0]  o_pos_x,
    output logic signed [gpt_pkg::CoordW-1:0]  o_pos_y,
    output logic signed [gpt_pkg::CoordW-1:0]  o_pos_z,
    output logic signed [gpt_pkg::CoordW-1:0]  o_min_x,
    output logic signed [gpt_pkg::CoordW-1:0]  o_max_x,
    output logic signed [gpt_pkg::CoordW-1:0]  o_min_y,
    output logic signed [gpt_pkg::CoordW-1:0]  o_max_y,
    output logic signed [gpt_pkg::CoordW-1:0]  o_min_z,
    output logic signed [gpt_pkg::CoordW-1:0]  o_max_z,
    output logic [5:0]                         o_bounds_valid
);
    gpt_pkg::t_cmd     f_cmd, q_cmd;
    logic              f_vld, q_full, q_empty, pop;
    gpt_pkg::t_coord   pos [3];
    gpt_pkg::t_coord   bnd [6];

    assign o_ready = !q_full;

    gpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (i_valid && !q_full),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .o_cmd       (f_cmd),
        .o_cmd_vld   (f_vld)
    );

    gpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    gpt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (!q_empty),
        .i_q_cmd (q_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pos   (pos),
        .o_bnd   (bnd),
        .o_flags (o_bounds_valid)
    );

    assign o_pos_x = pos[0];
    assign o_pos_y = pos[1];
    assign o_pos_z = pos[2];
    assign o_min_x = bnd[0];
    assign o_max_x = bnd[1];
    assign o_min_y = bnd[2];
    assign o_max_y = bnd[3];
    assign o_min_z = bnd[4];
    assign o_max_z = bnd[5];
endmodule
`default_nettype wire

@@ hw/rtl/gpt_checker.sv @@
// Port-level checker for the G-code tracker, bound to the top level.
// Depends on assert_macros.svh and gpt_pkg.
`default_nettype none
`include "assert_macros.svh"
module gpt_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 o_valid,
    input  wire logic                                 i_ready,
    input  wire logic signed [gpt_pkg::CoordW-1:0]    o_pos_x,
    input  wire logic signed [gpt_pkg::CoordW-1:0]    o_pos_y,
    input  wire logic signed [gpt_pkg::CoordW-1:0]    o_min_x,
    input  wire logic signed [gpt_pkg::CoordW-1:0]    o_max_x,
    input  wire logic [5:0]                           o_bounds_valid
);
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_pos_x))
    `ASSERT_IMPLY(a_pairs, i_clk, i_rst_n, o_valid, o_bounds_valid[0] == o_bounds_valid[1] && o_bounds_valid[2] == o_bounds_valid[3] && o_bounds_valid[4] == o_bounds_valid[5])
    `ASSERT_IMPLY(a_x_unmoved, i_clk, i_rst_n, o_valid && !o_bounds_valid[0], o_pos_x == '0)
    `ASSERT_IMPLY(a_x_inside, i_clk, i_rst_n, o_valid && o_bounds_valid[0], o_min_x <= o_pos_x && o_pos_x <= o_max_x)
    `ASSERT_IMPLY(a_y_unmoved, i_clk, i_rst_n, o_valid && !o_bounds_valid[2], o_pos_y == '0)
endmodule

bind gcode_position_and_bounds_tracker gpt_checker u_gpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pos_x        (o_pos_x),
    .o_pos_y        (o_pos_y),
    .o_min_x        (o_min_x),
    .o_max_x        (o_max_x),
    .o_bounds_valid (o_bounds_valid)
);
`default_nettype wire
